// ----- rtl/umq_pkg.sv -----
// Shared types and constants for the unsorted min queue.
// No dependencies; used by umq_ctrl, umq_dp and unsorted_min_queue_top.
package umq_pkg;

	localparam int CAPACITY = 128;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;
	localparam int COUNT_OUT_W = 8;

	localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_in;
		logic    init_scan;
		logic    issue_rd;
		logic    do_insert;
		logic    do_swap;
		logic    load_out;
		status_t status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op;
		logic full;
		logic empty;
		logic scan_last;
		logic out_busy;
	} sts_t;

endpackage

// ----- rtl/unsorted_min_queue_top.sv -----
// Unsorted-array min priority queue, 128 signed 32-bit entries in one RAM.
// An insert passes through the DECIDE, INSERT and DONE states, a rejected op through DECIDE
// and DONE, a remove through DECIDE, SCAN, DRAIN and DONE; the scan reads one entry per cycle
// through the single RAM read port. One item in flight; the next is taken the cycle after the
// result is registered, even while it waits for out_ready.
// Reset (arst_n, async low) empties the queue; entry contents stay undefined until written.
module unsorted_min_queue_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  op,
	input  logic signed [umq_pkg::DATA_W-1:0]     value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [umq_pkg::DATA_W-1:0]     removed_value,
	output logic signed [umq_pkg::DATA_W-1:0]     min_value,
	output logic [umq_pkg::COUNT_OUT_W-1:0]       count,
	output logic [1:0]                            status
);

	// controller/datapath split: all coupling goes through these two structs
	umq_pkg::cmd_t cmd;
	umq_pkg::sts_t sts;

	// FSM: accept, classify (full/empty/ok), insert or scan+swap, publish result
	umq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: entry RAM, one-pass min/second-min scan, cached minimum and
	// the output register that decouples the result from the next item
	umq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.value         (value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.removed_value (removed_value),
		.min_value     (min_value),
		.count         (count),
		.status        (status)
	);

endmodule

// ----- rtl/umq_ctrl.sv -----
// Sequencing FSM for the unsorted min queue.
// Depends on umq_pkg; drives umq_dp through cmd_t and reads sts_t.
module umq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  umq_pkg::sts_t sts,
	output umq_pkg::cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_INSERT = 6'b000100,
		S_SCAN   = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	umq_pkg::status_t st_q, st_d;
	logic swap_pend_q, swap_pend_d;

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		swap_pend_d = 1'b0;
		in_ready = 1'b0;
		cmd = '0;
		cmd.status = st_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				st_d = umq_pkg::ST_OK;
				if (sts.op == umq_pkg::OP_INSERT) begin
					if (sts.full) begin
						st_d = umq_pkg::ST_FULL;
						state_d = S_DONE;
					end else begin
						state_d = S_INSERT;
					end
				end else if (sts.empty) begin
					st_d = umq_pkg::ST_EMPTY;
					state_d = S_DONE;
				end else begin
					cmd.init_scan = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_INSERT: begin
				cmd.do_insert = 1'b1;
				state_d = S_DONE;
			end
			S_SCAN: begin
				cmd.issue_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last read is compared this cycle; swap follows in DONE
				swap_pend_d = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				cmd.do_swap = swap_pend_q;
				if (!sts.out_busy && !swap_pend_q) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= umq_pkg::ST_OK;
			swap_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
			swap_pend_q <= swap_pend_d;
		end
	end

endmodule

// ----- rtl/umq_dp.sv -----
// Datapath of the unsorted min queue: entry memory, scan compare, result register.
// Depends on umq_pkg; commanded by umq_ctrl.
module umq_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  umq_pkg::cmd_t                         cmd,
	output umq_pkg::sts_t                         sts,
	input  logic                                  op,
	input  logic signed [umq_pkg::DATA_W-1:0]     value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [umq_pkg::DATA_W-1:0]     removed_value,
	output logic signed [umq_pkg::DATA_W-1:0]     min_value,
	output logic [umq_pkg::COUNT_OUT_W-1:0]       count,
	output logic [1:0]                            status
);

	logic signed [umq_pkg::DATA_W-1:0] mem [umq_pkg::CAPACITY];

	logic                              op_q;
	logic signed [umq_pkg::DATA_W-1:0] val_q;
	logic [umq_pkg::CNT_W-1:0]         count_q;
	logic signed [umq_pkg::DATA_W-1:0] min_q;
	logic [umq_pkg::IDX_W-1:0]         idx_q;
	logic [umq_pkg::IDX_W-1:0]         pick_q;
	logic signed [umq_pkg::DATA_W-1:0] best_q;
	logic signed [umq_pkg::DATA_W-1:0] second_q;
	logic signed [umq_pkg::DATA_W-1:0] last_val_q;
	logic signed [umq_pkg::DATA_W-1:0] removed_q;
	logic signed [umq_pkg::DATA_W-1:0] rd_data_s1;
	logic [umq_pkg::IDX_W-1:0]         rd_idx_s1;
	logic                              rd_vld_s1;
	logic                              out_valid_q;

	logic [umq_pkg::IDX_W-1:0]         last_idx;
	logic                              we;
	logic [umq_pkg::IDX_W-1:0]         waddr;
	logic signed [umq_pkg::DATA_W-1:0] wdata;

	assign last_idx = umq_pkg::IDX_W'(count_q - umq_pkg::CNT_W'(1));

	assign sts.op        = op_q;
	assign sts.full      = (count_q == umq_pkg::CNT_W'(umq_pkg::CAPACITY));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = (idx_q == last_idx);
	assign sts.out_busy  = out_valid_q && !out_ready;

	// single write port: append on insert, move last entry into the hole on remove
	always_comb begin
		we = cmd.do_insert || cmd.do_swap;
		if (cmd.do_swap) begin
			waddr = pick_q;
			wdata = last_val_q;
		end else begin
			waddr = umq_pkg::IDX_W'(count_q);
			wdata = val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_s1 <= mem[idx_q];
		rd_idx_s1 <= idx_q;
	end

	// item capture and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= op;
			val_q <= value;
		end
		if (cmd.init_scan) begin
			idx_q <= '0;
			pick_q <= '0;
			best_q <= umq_pkg::INT_MAX;
			second_q <= umq_pkg::INT_MAX;
		end else begin
			if (cmd.issue_rd) begin
				idx_q <= idx_q + umq_pkg::IDX_W'(1);
			end
			if (rd_vld_s1) begin
				// strict compare keeps the lowest index among equal minima
				if (rd_data_s1 < best_q) begin
					second_q <= best_q;
					best_q <= rd_data_s1;
					pick_q <= rd_idx_s1;
				end else if (rd_data_s1 < second_q) begin
					second_q <= rd_data_s1;
				end
				if (rd_idx_s1 == last_idx) begin
					last_val_q <= rd_data_s1;
				end
			end
		end
		if (cmd.load_in) begin
			removed_q <= '0;
		end else if (cmd.do_swap) begin
			removed_q <= best_q;
		end
		if (cmd.load_out) begin
			removed_value <= removed_q;
			min_value <= min_q;
			count <= umq_pkg::COUNT_OUT_W'(count_q);
			status <= cmd.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			min_q <= umq_pkg::INT_MAX;
			rd_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue_rd;
			if (cmd.do_insert) begin
				count_q <= count_q + umq_pkg::CNT_W'(1);
				if (val_q < min_q) begin
					min_q <= val_q;
				end
			end else if (cmd.do_swap) begin
				count_q <= count_q - umq_pkg::CNT_W'(1);
				// second smallest of the scanned set is the new minimum
				min_q <= second_q;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= umq_pkg::CNT_W'(umq_pkg::CAPACITY))
		else $error("held count above capacity");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (min_q == umq_pkg::INT_MAX))
		else $error("empty queue with non-max minimum");

	a_swap_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_swap |=> (count_q == $past(count_q) - umq_pkg::CNT_W'(1)))
		else $error("remove did not shrink count");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue_rd |-> (umq_pkg::CNT_W'(idx_q) < count_q))
		else $error("scan read beyond held entries");

endmodule
